// ===== design/slp_pkg.sv =====
`timescale 1ns / 1ps

package slp_pkg;

    typedef enum logic [1:0] {
        PH_BEFORE      = 2'd0,
        PH_AFTER_QUOTE = 2'd1,
        PH_AFTER_S     = 2'd2,
        PH_DIGITS      = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        RX_BIN = 2'd0,
        RX_OCT = 2'd1,
        RX_DEC = 2'd2,
        RX_HEX = 2'd3
    } radix_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_DIGITS_AFTER_QUOTE = 3'd1,
        ST_BAD_BASE   = 3'd2,
        ST_NO_DIGITS  = 3'd3,
        ST_BAD_DIGIT  = 3'd4,
        ST_TOO_WIDE   = 3'd5,
        ST_DEC_XZ     = 3'd6
    } status_t;

    typedef struct packed {
        phase_t      phase;
        radix_t      radix;
        logic [63:0] value_acc;
        logic [63:0] unknown_acc;
        logic        overflow_seen;
        logic        bad_digit_seen;
        logic [6:0]  since_bad_digit;
        logic        digit_seen;
        logic        xz_seen;
        logic        bad_base;
    } slp_state_t;

    localparam logic [6:0] SINCE_SAT = 7'd64;

    localparam slp_state_t STATE_RESET = '{
        phase:           PH_BEFORE,
        radix:           RX_DEC,
        value_acc:       64'd0,
        unknown_acc:     64'd0,
        overflow_seen:   1'b0,
        bad_digit_seen:  1'b0,
        since_bad_digit: SINCE_SAT,
        digit_seen:      1'b0,
        xz_seen:         1'b0,
        bad_base:        1'b0
    };

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_QUOTE      = 8'h27;
    localparam logic [7:0] CH_S          = 8'h73;
    localparam logic [7:0] CH_B          = 8'h62;
    localparam logic [7:0] CH_O          = 8'h6F;
    localparam logic [7:0] CH_D          = 8'h64;
    localparam logic [7:0] CH_H          = 8'h68;
    localparam logic [7:0] CH_X          = 8'h78;
    localparam logic [7:0] CH_Z          = 8'h7A;
    localparam logic [7:0] CH_QMARK      = 8'h3F;
    localparam logic [7:0] CH_0          = 8'h30;
    localparam logic [7:0] CH_9          = 8'h39;
    localparam logic [7:0] CH_LA         = 8'h61;
    localparam logic [7:0] CH_LF         = 8'h66;
    localparam logic [7:0] CH_UA         = 8'h41;
    localparam logic [7:0] CH_UZ         = 8'h5A;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;

endpackage

// ===== design/slp_step.sv =====
`timescale 1ns / 1ps

module slp_step
    import slp_pkg::*;
(
    input  slp_state_t cur,
    input  logic [7:0] ch,
    output slp_state_t nxt
);

    logic [7:0]  lc;
    logic        is_xz;
    logic [4:0]  dval;
    logic [4:0]  rlim;
    logic [3:0]  gmask;
    logic [63:0] sv;
    logic [63:0] su;
    logic        top_bits;
    logic [6:0]  since_inc;
    logic [67:0] dec_sum;
    slp_state_t  dn;
    slp_state_t  cleared;

    always_comb
    begin
        lc = ((ch >= CH_UA) && (ch <= CH_UZ)) ? (ch + CASE_OFFSET) : ch;
        is_xz = (lc == CH_X) || (lc == CH_Z) || (lc == CH_QMARK);
        if ((lc >= CH_0) && (lc <= CH_9))
        begin
            dval = 5'(lc - CH_0);
        end
        else if ((lc >= CH_LA) && (lc <= CH_LF))
        begin
            dval = 5'(lc - CH_LA) + 5'd10;
        end
        else
        begin
            dval = 5'd16;
        end
    end

    always_comb
    begin
        case (cur.radix)
            RX_BIN:
            begin
                rlim     = 5'd2;
                gmask    = 4'b0001;
                sv       = {cur.value_acc[62:0], 1'b0};
                su       = {cur.unknown_acc[62:0], 1'b0};
                top_bits = cur.value_acc[63];
            end
            RX_OCT:
            begin
                rlim     = 5'd8;
                gmask    = 4'b0111;
                sv       = {cur.value_acc[60:0], 3'b0};
                su       = {cur.unknown_acc[60:0], 3'b0};
                top_bits = |cur.value_acc[63:61];
            end
            RX_DEC:
            begin
                rlim     = 5'd10;
                gmask    = 4'b1111;
                sv       = {cur.value_acc[59:0], 4'b0};
                su       = {cur.unknown_acc[59:0], 4'b0};
                top_bits = |cur.value_acc[63:60];
            end
            default:
            begin
                rlim     = 5'd16;
                gmask    = 4'b1111;
                sv       = {cur.value_acc[59:0], 4'b0};
                su       = {cur.unknown_acc[59:0], 4'b0};
                top_bits = |cur.value_acc[63:60];
            end
        endcase
    end

    assign since_inc = (cur.since_bad_digit < SINCE_SAT) ? (cur.since_bad_digit + 7'd1)
                                                         : cur.since_bad_digit;
    assign dec_sum = {1'b0, cur.value_acc, 3'b0} + {3'b0, cur.value_acc, 1'b0}
                   + {63'b0, dval};

    always_comb
    begin
        dn = cur;
        dn.digit_seen = 1'b1;
        if (is_xz)
        begin
            dn.xz_seen = 1'b1;
            dn.since_bad_digit = since_inc;
            if (cur.radix != RX_DEC)
            begin
                dn.value_acc     = sv | {60'b0, (lc == CH_X) ? 4'b0000 : gmask};
                dn.unknown_acc   = su | {60'b0, gmask};
                dn.overflow_seen = cur.overflow_seen | top_bits;
            end
        end
        else if (dval >= rlim)
        begin
            dn.bad_digit_seen  = 1'b1;
            dn.since_bad_digit = 7'd0;
            if (cur.radix != RX_DEC)
            begin
                dn.value_acc     = sv;
                dn.unknown_acc   = su;
                dn.overflow_seen = cur.overflow_seen | top_bits;
            end
        end
        else
        begin
            dn.since_bad_digit = since_inc;
            if (cur.radix == RX_DEC)
            begin
                dn.value_acc     = dec_sum[63:0];
                dn.unknown_acc   = 64'd0;
                dn.overflow_seen = cur.overflow_seen | (|dec_sum[67:64]);
            end
            else
            begin
                dn.value_acc     = sv | {60'b0, dval[3:0] & gmask};
                dn.unknown_acc   = su;
                dn.overflow_seen = cur.overflow_seen | top_bits;
            end
        end
    end

    always_comb
    begin
        cleared = STATE_RESET;
        cleared.radix    = cur.radix;
        cleared.bad_base = cur.bad_base;
        cleared.phase    = PH_AFTER_QUOTE;
    end

    always_comb
    begin
        nxt = cur;
        if (lc != CH_UNDERSCORE)
        begin
            case (cur.phase)
                PH_BEFORE:
                begin
                    nxt = (lc == CH_QUOTE) ? cleared : dn;
                end
                PH_AFTER_QUOTE, PH_AFTER_S:
                begin
                    if ((lc == CH_S) && (cur.phase == PH_AFTER_QUOTE))
                    begin
                        nxt.phase = PH_AFTER_S;
                    end
                    else
                    begin
                        nxt.phase = PH_DIGITS;
                        if (lc == CH_B)
                        begin
                            nxt.radix = RX_BIN;
                        end
                        else if (lc == CH_O)
                        begin
                            nxt.radix = RX_OCT;
                        end
                        else if (lc == CH_D)
                        begin
                            nxt.radix = RX_DEC;
                        end
                        else if (lc == CH_H)
                        begin
                            nxt.radix = RX_HEX;
                        end
                        else
                        begin
                            nxt.bad_base = 1'b1;
                        end
                    end
                end
                PH_DIGITS:
                begin
                    if (!cur.bad_base)
                    begin
                        nxt = dn;
                    end
                end
                default:
                begin
                    nxt = cur;
                end
            endcase
        end
    end

endmodule

// ===== design/slp_finish.sv =====
`timescale 1ns / 1ps

module slp_finish
    import slp_pkg::*;
(
    input  slp_state_t  st,
    input  logic [6:0]  width,
    output logic [63:0] value,
    output logic [63:0] unknown,
    output status_t     status
);

    logic [63:0] wmask;
    logic [2:0]  gbits;
    logic [9:0]  span;

    assign wmask = {64{1'b1}} >> (7'd64 - width);

    always_comb
    begin
        case (st.radix)
            RX_BIN:  gbits = 3'd1;
            RX_OCT:  gbits = 3'd3;
            default: gbits = 3'd4;
        endcase
    end

    assign span = 10'(st.since_bad_digit) * 10'(gbits);

    always_comb
    begin
        value   = 64'd0;
        unknown = 64'd0;
        if ((st.phase == PH_AFTER_QUOTE) || (st.phase == PH_AFTER_S))
        begin
            status = ST_NO_DIGITS_AFTER_QUOTE;
        end
        else if (st.bad_base)
        begin
            status = ST_BAD_BASE;
        end
        else if (!st.digit_seen)
        begin
            status = ST_NO_DIGITS;
        end
        else if (st.xz_seen)
        begin
            if (st.radix == RX_DEC)
            begin
                status = ST_DEC_XZ;
            end
            else if (st.bad_digit_seen && (span < {3'b0, width}))
            begin
                status = ST_BAD_DIGIT;
            end
            else
            begin
                status  = ST_OK;
                value   = st.value_acc & wmask;
                unknown = st.unknown_acc & wmask;
            end
        end
        else if (st.bad_digit_seen)
        begin
            status = ST_BAD_DIGIT;
        end
        else if (st.overflow_seen || ((st.value_acc & ~wmask) != 64'd0))
        begin
            status = ST_TOO_WIDE;
        end
        else
        begin
            status = ST_OK;
            value  = st.value_acc;
        end
    end

endmodule

// ===== design/sv_integer_literal_parser.sv =====
`timescale 1ns / 1ps

// Parses a SystemVerilog integer literal one character per beat and returns
// value plane, unknown plane and status in one output beat per literal.
// A beat is taken every cycle unless a finished result is still held at the
// output; each character passes through an input register and one step of
// decode and accumulate into the state register, and a closing character's
// result into the result register, with throughput of one character per
// cycle under that same condition. target_width is read only with the last
// character; 0 acts as 1, above MAX_WIDTH acts as MAX_WIDTH.

module sv_integer_literal_parser
    import slp_pkg::*;
#(
    parameter int MAX_WIDTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    input  logic [6:0]  target_width,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] value,
    output logic [63:0] unknown,
    output logic [2:0]  status
);

    localparam logic [6:0] MaxW = 7'(MAX_WIDTH);

    logic        in_valid_reg;
    logic [7:0]  ch_reg;
    logic [6:0]  width_reg;
    logic        last_reg;
    slp_state_t  state_reg;
    slp_state_t  state_next;
    logic        out_valid_reg;
    logic [63:0] value_reg;
    logic [63:0] unknown_reg;
    status_t     status_reg;

    logic        out_free;
    logic        advance;
    logic        in_fire;
    logic [6:0]  width_eff;
    logic [63:0] fin_value;
    logic [63:0] fin_unknown;
    status_t     fin_status;

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && (!last_reg || out_free);
    assign in_ready = !in_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    assign width_eff = (width_reg == 7'd0) ? 7'd1 :
                       ((width_reg > MaxW) ? MaxW : width_reg);

    slp_step u_step (
        .cur (state_reg),
        .ch  (ch_reg),
        .nxt (state_next)
    );

    slp_finish u_finish (
        .st      (state_next),
        .width   (width_eff),
        .value   (fin_value),
        .unknown (fin_unknown),
        .status  (fin_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ch_reg    <= ch;
            width_reg <= target_width;
            last_reg  <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= last_reg ? STATE_RESET : state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
        begin
            value_reg   <= fin_value;
            unknown_reg <= fin_unknown;
            status_reg  <= fin_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign unknown   = unknown_reg;
    assign status    = status_reg;

    // a character that does not close a literal never stalls
    a_mid_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !last_reg) |-> in_ready)
        else $error("non-last beat stalled");

    // error results carry empty planes
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> ((value == 64'd0) && (unknown == 64'd0)))
        else $error("error result with nonzero planes");

    // state returns to reset after a closing beat
    a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_reg) |=> ((state_reg.phase == PH_BEFORE) && !state_reg.digit_seen
                                   && !state_reg.bad_base))
        else $error("state not cleared after literal");

    // a closing beat always produces a result
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_reg) |=> out_valid)
        else $error("closing beat without result");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import slp_pkg::*;

    typedef struct packed {
        logic [63:0] vplane;
        logic [63:0] uplane;
        status_t     code;
    } lit_result_t;

    typedef struct {
        string       text;
        logic [6:0]  width;
        bit          typed;
        lit_result_t res;
    } lit_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  ch;
    logic [6:0]  target_width;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] value;
    logic [63:0] unknown;
    logic [2:0]  status;

    sv_integer_literal_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .ch           (ch),
        .target_width (target_width),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .value        (value),
        .unknown      (unknown),
        .status       (status)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // parser state mirror
    phase_t      ph;
    radix_t      rx;
    logic [63:0] v_acc;
    logic [63:0] u_acc;
    bit          ovf;
    bit          bad_dig;
    int unsigned since_bad;
    bit          dig_seen;
    bit          xz;
    bit          bbase;

    lit_result_t pending_literals[$];
    logic [7:0]  lit_buf[$];
    logic [6:0]  lit_width;
    lit_row_t    rows[11];

    int send_idle;
    int recv_idle;
    int stim_phase;
    logic hold_off;
    int chars_sent;
    int literals_sent;
    int results_checked;
    int mismatches;
    int status_seen[8];

    function automatic void add_char(input logic [7:0] c);
        lit_buf.insert(lit_buf.size(), c);
    endfunction

    function automatic int unsigned group_width();
        case (rx)
            RX_BIN:  return 1;
            RX_OCT:  return 3;
            default: return 4;
        endcase
    endfunction

    function automatic int unsigned radix_count();
        case (rx)
            RX_BIN:  return 2;
            RX_OCT:  return 8;
            RX_DEC:  return 10;
            default: return 16;
        endcase
    endfunction

    function automatic void clear_digits();
        v_acc = 64'd0;
        u_acc = 64'd0;
        ovf = 1'b0;
        bad_dig = 1'b0;
        since_bad = 64;
        dig_seen = 1'b0;
        xz = 1'b0;
    endfunction

    function automatic void reset_parse();
        ph = PH_BEFORE;
        rx = RX_DEC;
        bbase = 1'b0;
        clear_digits();
    endfunction

    function automatic void shift_group(input logic [63:0] vb, input logic [63:0] ub);
        int unsigned g;
        g = group_width();
        if ((v_acc >> (64 - g)) != 64'd0)
            ovf = 1'b1;
        v_acc = (v_acc << g) | vb;
        u_acc = (u_acc << g) | ub;
    endfunction

    function automatic void take_digit(input logic [7:0] c);
        logic [63:0] gmask;
        int unsigned d;
        gmask = (64'd1 << group_width()) - 64'd1;
        d = 16;
        dig_seen = 1'b1;
        if (c == CH_X || c == CH_Z || c == CH_QMARK)
        begin
            xz = 1'b1;
            if (rx != RX_DEC)
                shift_group((c == CH_X) ? 64'd0 : gmask, gmask);
            if (since_bad < 64)
                since_bad++;
            return;
        end
        if (c >= CH_0 && c <= CH_9)
            d = c - CH_0;
        else if (c >= CH_LA && c <= CH_LF)
            d = c - CH_LA + 10;
        if (d >= radix_count())
        begin
            bad_dig = 1'b1;
            since_bad = 0;
            if (rx != RX_DEC)
                shift_group(64'd0, 64'd0);
            return;
        end
        if (since_bad < 64)
            since_bad++;
        if (rx == RX_DEC)
        begin
            if (v_acc > (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / 64'd10)
                ovf = 1'b1;
            v_acc = v_acc * 64'd10 + 64'(d);
            u_acc = 64'd0;
        end
        else
        begin
            shift_group(64'(d), 64'd0);
        end
    endfunction

    function automatic void absorb_char(input logic [7:0] ch_in);
        logic [7:0] c;
        c = ch_in;
        if (c == CH_UNDERSCORE)
            return;
        if (c >= CH_UA && c <= CH_UZ)
            c = c + CASE_OFFSET;
        case (ph)
            PH_BEFORE:
            begin
                if (c == CH_QUOTE)
                begin
                    clear_digits();
                    ph = PH_AFTER_QUOTE;
                end
                else
                begin
                    take_digit(c);
                end
            end
            PH_AFTER_QUOTE, PH_AFTER_S:
            begin
                if (c == CH_S && ph == PH_AFTER_QUOTE)
                begin
                    ph = PH_AFTER_S;
                end
                else
                begin
                    if (c == CH_B)
                        rx = RX_BIN;
                    else if (c == CH_O)
                        rx = RX_OCT;
                    else if (c == CH_D)
                        rx = RX_DEC;
                    else if (c == CH_H)
                        rx = RX_HEX;
                    else
                        bbase = 1'b1;
                    ph = PH_DIGITS;
                end
            end
            default:
            begin
                if (!bbase)
                    take_digit(c);
            end
        endcase
    endfunction

    function automatic lit_result_t close_literal(input logic [6:0] w_in);
        int unsigned w;
        logic [63:0] wmask;
        lit_result_t r;
        w = w_in;
        if (w < 1)
            w = 1;
        if (w > 64)
            w = 64;
        wmask = (w >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << w) - 64'd1);
        r.vplane = 64'd0;
        r.uplane = 64'd0;
        r.code = ST_OK;
        if (ph == PH_AFTER_QUOTE || ph == PH_AFTER_S)
            r.code = ST_NO_DIGITS_AFTER_QUOTE;
        else if (bbase)
            r.code = ST_BAD_BASE;
        else if (!dig_seen)
            r.code = ST_NO_DIGITS;
        else if (xz)
        begin
            if (rx == RX_DEC)
                r.code = ST_DEC_XZ;
            else if (bad_dig && since_bad * group_width() < w)
                r.code = ST_BAD_DIGIT;
            else
            begin
                r.vplane = v_acc & wmask;
                r.uplane = u_acc & wmask;
            end
        end
        else if (bad_dig)
            r.code = ST_BAD_DIGIT;
        else if (ovf || (v_acc & ~wmask) != 64'd0)
            r.code = ST_TOO_WIDE;
        else
            r.vplane = v_acc;
        reset_parse();
        return r;
    endfunction

    task automatic send_literal(input logic [7:0] chars[$], input logic [6:0] w,
                                input bit typed, input lit_result_t fixed);
        int n;
        lit_result_t r;
        n = chars.size();
        for (int i = 0; i < n; i++)
        begin
            while ($urandom_range(99) < send_idle)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            ch <= chars[i];
            target_width <= w;
            last <= (i == n - 1);
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            absorb_char(chars[i]);
            chars_sent++;
            if (i == n - 1)
            begin
                r = close_literal(w);
                pending_literals.insert(pending_literals.size(), typed ? fixed : r);
            end
        end
        literals_sent++;
    endtask

    task automatic build_literal();
        int unsigned kind, ndig, g, r, d, roll, tw;
        radix_t br;
        logic [7:0] c;
        lit_buf.delete();
        kind = $urandom_range(99);
        if (kind < 12)
        begin
            repeat ($urandom_range(1, 5))
                add_char(8'($urandom_range(255)));
            lit_width = 7'($urandom_range(127));
            return;
        end
        br = RX_DEC;
        if (kind >= 24)
        begin
            if ($urandom_range(1))
                repeat ($urandom_range(1, 2))
                    add_char(8'(CH_0 + $urandom_range(9)));
            add_char(CH_QUOTE);
            if ($urandom_range(99) < 3)
            begin
                lit_width = 7'($urandom_range(1, 64));
                return;
            end
            if ($urandom_range(99) < 30)
                add_char($urandom_range(1) ? CH_S : CH_S - CASE_OFFSET);
            br = radix_t'($urandom_range(3));
            case (br)
                RX_BIN:  c = CH_B;
                RX_OCT:  c = CH_O;
                RX_DEC:  c = CH_D;
                default: c = CH_H;
            endcase
            if ($urandom_range(99) < 30)
                c = c - CASE_OFFSET;
            if ($urandom_range(99) < 4)
                c = $urandom_range(1) ? CH_S : 8'($urandom_range(255));
            add_char(c);
            if ($urandom_range(99) < 3)
            begin
                lit_width = 7'($urandom_range(1, 64));
                return;
            end
        end
        case (br)
            RX_BIN:  begin g = 1; r = 2;  end
            RX_OCT:  begin g = 3; r = 8;  end
            RX_DEC:  begin g = 4; r = 10; end
            default: begin g = 4; r = 16; end
        endcase
        if ($urandom_range(7) == 0)
            ndig = $urandom_range(9, (br == RX_BIN) ? 68 : (br == RX_OCT) ? 23 :
                                     (br == RX_DEC) ? 21 : 17);
        else
            ndig = $urandom_range(1, 8);
        for (int i = 0; i < ndig; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 6)
            begin
                case ($urandom_range(2))
                    0:       c = CH_X;
                    1:       c = CH_Z;
                    default: c = CH_QMARK;
                endcase
                if (c != CH_QMARK && $urandom_range(99) < 30)
                    c = c - CASE_OFFSET;
            end
            else if (roll < 9)
            begin
                if (r < 10 && $urandom_range(1))
                    c = 8'(CH_0 + $urandom_range(r, 9));
                else if ($urandom_range(1))
                    c = 8'(CH_LA + $urandom_range(6, 21));
                else
                    c = 8'($urandom_range(255));
            end
            else
            begin
                d = $urandom_range(r - 1);
                c = (d < 10) ? 8'(CH_0 + d) : 8'(CH_LA + d - 10);
                if (d >= 10 && $urandom_range(1))
                    c = c - CASE_OFFSET;
            end
            add_char(c);
            if ($urandom_range(99) < 5)
                add_char(CH_UNDERSCORE);
        end
        roll = $urandom_range(99);
        if (roll < 60)
            tw = $urandom_range(1, 64);
        else if (roll < 75)
            tw = $urandom_range(127);
        else
        begin
            tw = ndig * g + $urandom_range(2);
            tw = (tw > 0) ? tw - 1 : 0;
            if (tw > 127)
                tw = 127;
        end
        lit_width = 7'(tw);
    endtask

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
                out_ready <= !hold_off && ($urandom_range(99) >= recv_idle);
        end
    end

    // long receiver stall so the input side backs up
    initial
    begin
        hold_off <= 1'b0;
        wait (stim_phase == 2);
        repeat (3) @(posedge clk);
        hold_off <= 1'b1;
        repeat (80) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin : check_results
        lit_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_literals.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at %0t: value %h unknown %h status %0d",
                             $time, value, unknown, status);
            end
            else
            begin
                want = pending_literals.pop_front();
                results_checked++;
                if (value !== want.vplane || unknown !== want.uplane ||
                    status !== want.code)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch at %0t (expected/actual): value %h/%h ",
                                  "unknown %h/%h status %0d/%0d"},
                                 $time, want.vplane, value, want.uplane, unknown,
                                 want.code, status);
                end
                else
                begin
                    status_seen[status]++;
                end
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        lit_result_t blank;
        logic [7:0] q[$];
        blank.vplane = 64'd0;
        blank.uplane = 64'd0;
        blank.code = ST_OK;
        in_valid <= 1'b0;
        ch <= 8'd0;
        target_width <= 7'd0;
        last <= 1'b0;
        send_idle <= 0;
        recv_idle <= 0;
        stim_phase <= 0;
        rst_n <= 1'b0;
        reset_parse();

        rows[0]  = '{"'",    7'd8,   1'b1, '{64'd0,  64'd0,  ST_NO_DIGITS_AFTER_QUOTE}};
        rows[1]  = '{"'q1",  7'd8,   1'b1, '{64'd0,  64'd0,  ST_BAD_BASE}};
        rows[2]  = '{"'h",   7'd8,   1'b1, '{64'd0,  64'd0,  ST_NO_DIGITS}};
        rows[3]  = '{"'dx",  7'd8,   1'b1, '{64'd0,  64'd0,  ST_DEC_XZ}};
        rows[4]  = '{"'b1_", 7'd1,   1'b1, '{64'd1,  64'd0,  ST_OK}};
        rows[5]  = '{"7",    7'd0,   1'b1, '{64'd0,  64'd0,  ST_TOO_WIDE}};
        rows[6]  = '{"'hZ",  7'd127, 1'b1, '{64'hF,  64'hF,  ST_OK}};
        rows[7]  = '{"'ss",  7'd8,   1'b1, '{64'd0,  64'd0,  ST_BAD_BASE}};
        rows[8]  = '{"'b'",  7'd8,   1'b1, '{64'd0,  64'd0,  ST_BAD_DIGIT}};
        rows[9]  = '{"'O?",  7'd2,   1'b0, '{64'd0,  64'd0,  ST_OK}};
        rows[10] = '{"'HF",  7'd4,   1'b1, '{64'hF,  64'd0,  ST_OK}};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle <= 15;
        recv_idle <= 62;
        foreach (rows[r])
        begin
            q.delete();
            for (int k = 0; k < rows[r].text.len(); k++)
                q.insert(q.size(), rows[r].text[k]);
            send_literal(q, rows[r].width, rows[r].typed, rows[r].res);
        end

        while (chars_sent < 660)
        begin
            build_literal();
            send_literal(lit_buf, lit_width, 1'b0, blank);
        end
        send_idle <= 62;
        recv_idle <= 15;
        stim_phase <= 1;
        while (chars_sent < 1300)
        begin
            build_literal();
            send_literal(lit_buf, lit_width, 1'b0, blank);
        end
        send_idle <= 0;
        recv_idle <= 0;
        stim_phase <= 2;
        while (chars_sent < 1940)
        begin
            build_literal();
            send_literal(lit_buf, lit_width, 1'b0, blank);
        end
        in_valid <= 1'b0;
        last <= 1'b0;

        while (pending_literals.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        $display("sent %0d literals in %0d characters, %0d results checked",
                 literals_sent, chars_sent, results_checked);
        $display({"matched by status ok/quote/base/none/digit/wide/decxz: ",
                  "%0d %0d %0d %0d %0d %0d %0d"},
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6]);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
